// ===== rtl/scrs_pkg.sv =====
// shared types, codes and helpers for the sensor change report scheduler
package scrs_pkg;

    localparam int unsigned SLOT_COUNT_DEFAULT = 11;
    localparam int unsigned ID_W               = 16;
    localparam int unsigned VALUE_W            = 32;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned SLOT_W             = 4;
    localparam int unsigned ACTION_W           = 2;
    localparam int unsigned KIND_W             = 2;

    localparam logic [ID_W-1:0]   LAST_SLOT_ID       = 16'd100;
    localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = 32'd200;

    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SCAN   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     target_id;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  sample_value;
        logic [TIME_W-1:0]   now_ms;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    reported_id;
        logic [VALUE_W-1:0] reported_value;
        logic               last_of_run;
    } rsp_t;

    // one table row: current value, last reported value, last report time
    typedef struct packed {
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] rep;
        logic [TIME_W-1:0]  stamp;
    } slot_entry_t;

    // last slot carries the fixed id, the others index plus one
    function automatic logic [ID_W-1:0] slot_id(int unsigned idx, int unsigned count);
        if (idx == count - 1)
            return LAST_SLOT_ID;
        return ID_W'(idx + 1);
    endfunction

endpackage

// ===== rtl/sensor_change_report_scheduler.sv =====
// sensor change report scheduler: slot table in a synchronous memory, start/stop/sample/scan
// a start/stop ack is registered in ST_CMD once the output is free; a sample is written in ST_SAMPLE
// a scan walks the table one slot per cycle out of the memory read port, holding while a report
// waits on a stalled output; one input word is in work at a time
// reset: all slots disabled, every table row reads as zero, min interval back to 200 ms
module sensor_change_report_scheduler #(
    parameter int unsigned SLOT_COUNT = scrs_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  scrs_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output scrs_pkg::rsp_t               rsp,
    input  logic                         cfg_we,
    input  logic [scrs_pkg::TIME_W-1:0]  cfg_wdata
);
    import scrs_pkg::*;

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMD    = 3'd1;
    localparam logic [2:0] ST_SAMPLE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    req_t                  req_reg;
    logic                  found_reg, found_next;
    logic [TIME_W-1:0]     min_interval_reg;
    logic [SLOT_COUNT-1:0] enabled_reg, enabled_next;
    logic [SLOT_COUNT-1:0] written_reg, written_next;

    // slot table
    slot_entry_t           mem [SLOT_COUNT];
    slot_entry_t           mem_q_reg;
    logic                  q_valid_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    slot_entry_t           mem_wdata;
    slot_entry_t           entry;

    // report held back until we know whether another one follows
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    logic [VALUE_W-1:0]    pend_value_reg, pend_value_next;

    logic                  out_valid_reg;
    rsp_t                  out_reg;
    logic                  out_load;
    rsp_t                  out_data;
    logic                  out_free;

    logic                  req_take;
    logic                  lookup_hit;
    logic [IDX_W-1:0]      lookup_idx;
    logic                  sample_ok;
    logic [TIME_W-1:0]     elapsed;
    logic                  hit;
    logic                  scan_hold;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign entry     = q_valid_reg ? mem_q_reg : slot_entry_t'('0);

    // id lookup over the fixed id list
    always_comb
    begin
        lookup_hit = 1'b0;
        lookup_idx = '0;
        for (int unsigned i = 0; i < SLOT_COUNT; i++)
        begin
            if (req.target_id == slot_id(i, SLOT_COUNT))
            begin
                lookup_hit = 1'b1;
                lookup_idx = IDX_W'(i);
            end
        end
    end

    assign sample_ok = ({1'b0, req.slot} < SLOT_LIMIT) && enabled_reg[req.slot[IDX_W-1:0]];
    assign elapsed   = req_reg.now_ms - entry.stamp;
    assign hit       = enabled_reg[idx_reg] && (elapsed > min_interval_reg)
                       && (entry.cur != entry.rep);
    assign scan_hold = hit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        enabled_next    = enabled_reg;
        written_next    = written_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_value_next = pend_value_reg;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        mem_wdata       = entry;
        out_load        = 1'b0;
        out_data        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req.action)
                        ACT_START, ACT_STOP:
                        begin
                            idx_next   = lookup_idx;
                            rd_addr    = lookup_idx;
                            found_next = lookup_hit;
                            state_next = ST_CMD;
                        end
                        ACT_SAMPLE:
                        begin
                            idx_next = req.slot[IDX_W-1:0];
                            rd_addr  = req.slot[IDX_W-1:0];
                            if (sample_ok)
                                state_next = ST_SAMPLE;
                        end
                        ACT_SCAN:
                        begin
                            idx_next   = '0;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CMD:
            begin
                if (out_free)
                begin
                    out_load                = 1'b1;
                    out_data.kind           = found_reg ? KIND_ACCEPT : KIND_REJECT;
                    out_data.reported_id    = req_reg.target_id;
                    out_data.reported_value = '0;
                    out_data.last_of_run    = 1'b1;
                    if (found_reg)
                    begin
                        if (req_reg.action == ACT_START)
                        begin
                            enabled_next[idx_reg] = 1'b1;
                            written_next[idx_reg] = 1'b1;
                            mem_we                = 1'b1;
                            mem_wdata.rep         = '0;
                        end
                        else
                        begin
                            enabled_next[idx_reg] = 1'b0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SAMPLE:
            begin
                written_next[idx_reg] = 1'b1;
                mem_we                = 1'b1;
                mem_wdata.cur         = req_reg.sample_value;
                state_next            = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (!scan_hold)
                begin
                    if (hit)
                    begin
                        written_next[idx_reg] = 1'b1;
                        mem_we                = 1'b1;
                        mem_wdata.rep         = entry.cur;
                        mem_wdata.stamp       = req_reg.now_ms;
                        if (pend_valid_reg)
                        begin
                            out_load                = 1'b1;
                            out_data.kind           = KIND_REPORT;
                            out_data.reported_id    = pend_id_reg;
                            out_data.reported_value = pend_value_reg;
                            out_data.last_of_run    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = slot_id(int'(idx_reg), SLOT_COUNT);
                        pend_value_next = entry.cur;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load                = 1'b1;
                    out_data.kind           = KIND_REPORT;
                    out_data.reported_id    = pend_id_reg;
                    out_data.reported_value = pend_value_reg;
                    out_data.last_of_run    = 1'b1;
                    pend_valid_next         = 1'b0;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            found_reg        <= 1'b0;
            enabled_reg      <= '0;
            written_reg      <= '0;
            q_valid_reg      <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            min_interval_reg <= MIN_INTERVAL_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            enabled_reg    <= enabled_next;
            written_reg    <= written_next;
            q_valid_reg    <= written_reg[rd_addr];
            pend_valid_reg <= pend_valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
                min_interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req;
        pend_id_reg    <= pend_id_next;
        pend_value_reg <= pend_value_next;
        if (out_load)
            out_reg <= out_data;
    end

    // synchronous table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= mem_wdata;
        mem_q_reg <= mem[rd_addr];
    end

endmodule

// ===== dv/tb_sensor_change_report_scheduler.sv =====
// testbench for the sensor change report scheduler: queued driver, clocked monitor, predictor
module tb_sensor_change_report_scheduler;
    import scrs_pkg::*;

    localparam int NSLOT      = SLOT_COUNT_DEFAULT;
    localparam int MAX_GAP    = 6;
    localparam int SETTLE_CYC = NSLOT + 12;

    typedef struct {
        req_t word;
        int   gap;
        bit   drain;
    } pend_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    logic              cfg_we;
    logic [TIME_W-1:0] cfg_wdata;

    pend_t             pend_q[$];
    rsp_t              expected_rsps[$];
    int                mismatch_count = 0;
    bit                req_taken = 1'b0;
    bit                rsp_taken = 1'b0;
    int                send_gap = 0;
    int                recv_gap = 0;
    int                calm_left = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    // shadow copy of the slot table
    logic               tb_enabled [NSLOT];
    logic [VALUE_W-1:0] tb_cur     [NSLOT];
    logic [VALUE_W-1:0] tb_rep     [NSLOT];
    logic [TIME_W-1:0]  tb_stamp   [NSLOT];
    logic [TIME_W-1:0]  tb_interval;

    sensor_change_report_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [ID_W-1:0] sensor_of(input int i);
        if (i == NSLOT - 1)
            return LAST_SLOT_ID;
        return ID_W'(i + 1);
    endfunction

    task automatic predict_word(input req_t w);
        int               idx;
        int               last_i;
        logic [NSLOT-1:0] hit;
        rsp_t             r;
        idx = NSLOT;
        case (w.action)
            ACT_START, ACT_STOP:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (sensor_of(i) == w.target_id)
                        idx = i;
                r.kind           = (idx == NSLOT) ? KIND_REJECT : KIND_ACCEPT;
                r.reported_id    = w.target_id;
                r.reported_value = '0;
                r.last_of_run    = 1'b1;
                if (idx < NSLOT)
                begin
                    if (w.action == ACT_START)
                    begin
                        tb_enabled[idx] = 1'b1;
                        tb_rep[idx]     = '0;
                    end
                    else
                        tb_enabled[idx] = 1'b0;
                end
                expected_rsps.push_back(r);
            end
            ACT_SAMPLE:
            begin
                if (w.slot < NSLOT && tb_enabled[w.slot])
                    tb_cur[w.slot] = w.sample_value;
            end
            default:
            begin
                // mark reporting slots first so the last one carries the run flag
                hit    = '0;
                last_i = -1;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (tb_enabled[i] && (w.now_ms - tb_stamp[i]) > tb_interval
                        && tb_cur[i] != tb_rep[i])
                    begin
                        hit[i] = 1'b1;
                        last_i = i;
                    end
                end
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (hit[i])
                    begin
                        r.kind           = KIND_REPORT;
                        r.reported_id    = sensor_of(i);
                        r.reported_value = tb_cur[i];
                        r.last_of_run    = (i == last_i);
                        expected_rsps.push_back(r);
                        tb_stamp[i] = w.now_ms;
                        tb_rep[i]   = tb_cur[i];
                    end
                end
            end
        endcase
    endtask

    // request side: one word at a time, with its drawn gap after acceptance
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pend_q.size() != 0 && !(pend_q[0].drain && expected_rsps.size() != 0))
            begin
                req       <= pend_q[0].word;
                send_gap  <= pend_q[0].gap;
                req_valid <= 1'b1;
                void'(pend_q.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response side: stall for a drawn count after each word, with calm stretches
    always @(negedge clk)
    begin : recv_side
        int g;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (rsp_taken)
            begin
                if (calm_left > 0)
                begin
                    g = 0;
                    calm_left <= calm_left - 1;
                end
                else
                begin
                    g = $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 15) == 0)
                        calm_left <= 20;
                end
            end
            else
                g = recv_gap;
            rsp_stall <= (g > 0);
            recv_gap  <= (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            req_taken   <= 1'b0;
            rsp_taken   <= 1'b0;
            tb_interval = MIN_INTERVAL_RESET;
            for (int i = 0; i < NSLOT; i++)
            begin
                tb_enabled[i] = 1'b0;
                tb_cur[i]     = '0;
                tb_rep[i]     = '0;
                tb_stamp[i]   = '0;
            end
        end
        else
        begin
            req_taken <= req_valid && !req_stall;
            rsp_taken <= rsp_valid && !rsp_stall;
            if (cfg_we)
                tb_interval = cfg_wdata;
            if (req_valid && !req_stall)
                predict_word(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected nothing, actual kind=%0d id=%0d value=%h last=%0d",
                             $time, rsp.kind, rsp.reported_id, rsp.reported_value,
                             rsp.last_of_run);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.kind !== want.kind || rsp.reported_id !== want.reported_id
                        || rsp.reported_value !== want.reported_value
                        || rsp.last_of_run !== want.last_of_run)
                    begin
                        mismatch_count++;
                        $display("%0t: expected kind=%0d id=%0d value=%h last=%0d,",
                                 $time, want.kind, want.reported_id, want.reported_value,
                                 want.last_of_run,
                                 " actual kind=%0d id=%0d value=%h last=%0d",
                                 rsp.kind, rsp.reported_id, rsp.reported_value,
                                 rsp.last_of_run);
                    end
                end
            end
        end
    end

    task automatic queue_word(input logic [ACTION_W-1:0] action, input logic [ID_W-1:0] id,
                              input logic [SLOT_W-1:0] slot, input logic [VALUE_W-1:0] value,
                              input logic [TIME_W-1:0] now, input bit drain);
        pend_t p;
        p.word.action       = action;
        p.word.target_id    = id;
        p.word.slot         = slot;
        p.word.sample_value = value;
        p.word.now_ms       = now;
        p.gap               = $urandom_range(0, MAX_GAP);
        p.drain             = drain;
        pend_q.push_back(p);
    endtask

    task automatic random_words(input int count);
        pend_t p;
        int    pick;
        int    calm;
        calm = 0;
        for (int k = 0; k < count; k++)
        begin
            p.word.action       = ACTION_W'($urandom_range(0, 3));
            p.word.target_id    = ID_W'($urandom_range(0, 65535));
            p.word.slot         = SLOT_W'($urandom_range(0, 15));
            p.word.sample_value = $urandom;
            p.word.now_ms       = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 22)
            begin
                p.word.action = (pick < 14) ? ACT_START : ACT_STOP;
                if ($urandom_range(0, 4) != 0)
                    p.word.target_id = sensor_of(int'($urandom_range(0, NSLOT - 1)));
            end
            else if (pick < 62)
            begin
                p.word.action = ACT_SAMPLE;
                if ($urandom_range(0, 9) != 0)
                    p.word.slot = SLOT_W'($urandom_range(0, NSLOT - 1));
                case ($urandom_range(0, 3))
                    0: p.word.sample_value = '0;
                    1: p.word.sample_value = '1;
                    default: ;
                endcase
            end
            else
            begin
                p.word.action = ACT_SCAN;
                if ($urandom_range(0, 15) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 700);
                p.word.now_ms = clock_ms;
            end
            if (calm > 0)
            begin
                calm--;
                p.gap = 0;
            end
            else
            begin
                p.gap = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 19) == 0)
                    calm = 25;
            end
            p.drain = ($urandom_range(0, 39) == 0);
            pend_q.push_back(p);
        end
    endtask

    // block may still be busy on a sample after the last result, so settle too
    task automatic wait_idle();
        while (pend_q.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_interval(input logic [TIME_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown ids, start/stop, ignored samples, boundary and wrapped elapsed time
        queue_word(ACT_SCAN,   16'd7,     4'd2,  32'hDEADBEEF, 32'd1000,     1'b0);
        queue_word(ACT_START,  16'd0,     4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_START,  16'hFFFF,  4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        queue_word(ACT_STOP,   16'd11,    4'd5,  32'h5A5A5A5A, 32'hA5A5A5A5, 1'b0);
        queue_word(ACT_START,  16'd100,   4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_START,  16'd1,     4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_START,  16'd10,    4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'hFFFF,  4'd0,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd10, 32'h12345678, 32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd9,  32'h00000001, 32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd11, 32'h11111111, 32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd15, 32'h22222222, 32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd3,  32'h00000005, 32'h0,        1'b0);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'd200,      1'b0);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'd201,      1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'hFFFFFFFF, 1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd0,  32'h7,        32'h0,        1'b0);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'd200,      1'b0);
        queue_word(ACT_START,  16'd1,     4'd0,  32'h0,        32'h0,        1'b1);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'h400,      1'b0);
        queue_word(ACT_STOP,   16'd100,   4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_STOP,   16'd100,   4'd0,  32'h0,        32'h0,        1'b0);
        queue_word(ACT_SAMPLE, 16'd0,     4'd10, 32'h0,        32'h0,        1'b0);
        queue_word(ACT_SCAN,   16'd0,     4'd0,  32'h0,        32'hFFFFFF00, 1'b0);
        clock_ms = 32'hFFFFFF00;

        random_words(60);
        wait_idle();
        write_interval('0);
        random_words(60);
        wait_idle();
        write_interval('1);
        random_words(30);
        wait_idle();
        write_interval($urandom_range(1, 1000));
        random_words(45);
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Mismatches found");
        $finish;
    end

endmodule
